FILE: rtl/core/ptpt_pkg.sv
// ----------------------------------------------------------------------------
// ptpt_pkg: shared types and constants for the peer table packet tracker
// Request and result beats, table entry layout, status codes, table sizing.
// ----------------------------------------------------------------------------
package ptpt_pkg;

    localparam int MAX_PEERS = 8;
    localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);

    // configuration register indexes
    localparam logic [3:0] CFG_EXPECTED_LENGTH = 4'd0;
    localparam logic [3:0] CFG_MAGIC_FIRST     = 4'd1;
    localparam logic [3:0] CFG_MAGIC_SECOND    = 4'd2;
    localparam logic [3:0] CFG_FORMAT_VERSION  = 4'd3;

    // request types
    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // result status codes
    localparam logic [2:0] ST_EXISTING    = 3'd0;
    localparam logic [2:0] ST_NEW         = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_READ_OK     = 3'd6;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd7;

    typedef struct packed {
        logic        req_type;
        logic [47:0] src_mac;
        logic [7:0]  length_bytes;
        logic [7:0]  magic_a;
        logic [7:0]  magic_b;
        logic [7:0]  pkt_version;
        logic [31:0] now_ms;
        logic [5:0]  read_index;
    } ptpt_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  peer_index;
        logic [47:0] entry_mac;
        logic [31:0] entry_last_ms;
        logic [31:0] entry_packets;
        logic [6:0]  peers_in_use;
        logic [31:0] total_accepted;
    } ptpt_rsp_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] last_ms;
        logic [31:0] packets;
    } ptpt_entry_t;

endpackage

FILE: rtl/core/peer_table_packet_tracker.sv
// ----------------------------------------------------------------------------
// peer_table_packet_tracker: per-peer packet statistics table
// Checks arriving packets, learns sender MACs into a small table and counts
// packets per peer and in total; read requests return one table entry.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a beat on request is taken at a clock edge with start
//   high and busy low. Result channel: done is high for one cycle with the
//   result beat; the receiver cannot stall it, so it must take it then.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Write config only while no request is in flight.
// Request handling:
//   Rejected packets and out-of-range reads: result in the cycle after accept.
//   Good reads: one synchronous table read, then the registered result.
//   Good packets: the table is walked one entry per cycle from index 0;
//   the walk ends at the first matching entry or after the last occupied
//   one, and an empty table is appended to without a walk. busy is high during
//   the walk; a new request may be started in the cycle done is high.
// Reset: counters, configuration and control clear; table contents are
//   not cleared, only entries below the occupied count are ever read.
// ----------------------------------------------------------------------------
module peer_table_packet_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptpt_pkg::ptpt_cmd_t request,
    output logic               done,
    output ptpt_pkg::ptpt_rsp_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import ptpt_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RD_WAIT = 2'd1;
    localparam logic [1:0] S_SCAN    = 2'd2;

    logic [1:0]       state_reg, state_next;
    ptpt_cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      total_reg, total_next;
    logic             done_reg, done_next;
    ptpt_rsp_t        rsp_reg, rsp_next;

    logic [7:0] exp_len_reg, magic1_reg, magic2_reg, version_reg;

    // peer table
    ptpt_entry_t      mem [MAX_PEERS];
    ptpt_entry_t      rd_data_reg;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    ptpt_entry_t      mem_wr_data;

    logic             cfg_write;
    logic [6:0]       ridx_ext;
    logic [6:0]       used_ext;
    logic [CNT_W-1:0] scan_plus1;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;

    assign ridx_ext   = {1'b0, request.read_index};
    assign used_ext   = 7'(used_reg);
    assign scan_plus1 = CNT_W'(scan_reg) + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            magic1_reg  <= '0;
            magic2_reg  <= '0;
            version_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_LENGTH: exp_len_reg <= cfg_data;
                CFG_MAGIC_FIRST:     magic1_reg  <= cfg_data;
                CFG_MAGIC_SECOND:    magic2_reg  <= cfg_data;
                CFG_FORMAT_VERSION:  version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        scan_next   = scan_reg;
        used_next   = used_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request;
                    rsp_next = '0;
                    if (request.req_type == REQ_READ)
                    begin
                        if (ridx_ext < used_ext)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = request.read_index[IDX_W-1:0];
                            state_next  = S_RD_WAIT;
                        end
                        else
                        begin
                            done_next           = 1'b1;
                            rsp_next.status     = ST_BAD_INDEX;
                            rsp_next.peer_index = request.read_index;
                        end
                    end
                    else if (request.length_bytes != exp_len_reg)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_BAD_LENGTH;
                    end
                    else if (request.magic_a != magic1_reg || request.magic_b != magic2_reg)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_BAD_MAGIC;
                    end
                    else if (request.pkt_version != version_reg)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_BAD_VERSION;
                    end
                    else if (used_reg == '0)
                    begin
                        // empty table: append at entry 0 without a walk
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = '{mac: request.src_mac, last_ms: request.now_ms,
                                        packets: 32'd1};
                        used_next   = CNT_W'(1);
                        total_next  = total_reg + 32'd1;
                        done_next   = 1'b1;
                        rsp_next    = '{status: ST_NEW, peer_index: 6'd0,
                                        entry_mac: request.src_mac,
                                        entry_last_ms: request.now_ms,
                                        entry_packets: 32'd1,
                                        peers_in_use: 7'd0, total_accepted: 32'd0};
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        scan_next   = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_RD_WAIT:
            begin
                done_next  = 1'b1;
                rsp_next   = '{status: ST_READ_OK, peer_index: cmd_reg.read_index,
                               entry_mac: rd_data_reg.mac,
                               entry_last_ms: rd_data_reg.last_ms,
                               entry_packets: rd_data_reg.packets,
                               peers_in_use: 7'd0, total_accepted: 32'd0};
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // rd_data_reg holds entry scan_reg
                if (rd_data_reg.mac == cmd_reg.src_mac)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = scan_reg;
                    mem_wr_data = '{mac: rd_data_reg.mac, last_ms: cmd_reg.now_ms,
                                    packets: rd_data_reg.packets + 32'd1};
                    total_next  = total_reg + 32'd1;
                    done_next   = 1'b1;
                    rsp_next    = '{status: ST_EXISTING, peer_index: 6'(scan_reg),
                                    entry_mac: rd_data_reg.mac,
                                    entry_last_ms: cmd_reg.now_ms,
                                    entry_packets: rd_data_reg.packets + 32'd1,
                                    peers_in_use: 7'd0, total_accepted: 32'd0};
                    state_next  = S_IDLE;
                end
                else if (scan_plus1 < used_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(scan_plus1);
                    scan_next   = IDX_W'(scan_plus1);
                end
                else if (used_reg == CNT_W'(MAX_PEERS))
                begin
                    done_next       = 1'b1;
                    rsp_next        = '0;
                    rsp_next.status = ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(used_reg);
                    mem_wr_data = '{mac: cmd_reg.src_mac, last_ms: cmd_reg.now_ms,
                                    packets: 32'd1};
                    used_next   = used_reg + CNT_W'(1);
                    total_next  = total_reg + 32'd1;
                    done_next   = 1'b1;
                    rsp_next    = '{status: ST_NEW, peer_index: 6'(used_reg),
                                    entry_mac: cmd_reg.src_mac,
                                    entry_last_ms: cmd_reg.now_ms,
                                    entry_packets: 32'd1,
                                    peers_in_use: 7'd0, total_accepted: 32'd0};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // counters always report the state after the item
        if (done_next)
        begin
            rsp_next.peers_in_use   = 7'(used_next);
            rsp_next.total_accepted = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scan_reg  <= '0;
            used_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_PEERS))
        else $error("occupied count above table size");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither finished nor in progress");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("occupied count moved by other than zero or one");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_NEW) |-> (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("new peer without table growth");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_NEW || result.status == ST_EXISTING))
            |-> (total_reg == $past(total_reg) + 32'd1))
        else $error("accepted packet did not bump the total");

endmodule
